/* rtl/css_tc_pkg.sv */
// Shared types, codes and character helpers for the CSS token classifier.
package css_tc_pkg;

	localparam int POSITION_WIDTH_DEF = 32;
	localparam int OUT_POS_W = 32;
	localparam int MAX_RES = 3;
	localparam int HEX_DEPTH = 8;

	// token kinds
	localparam logic [3:0] K_ELEM   = 4'd0;
	localparam logic [3:0] K_ID     = 4'd1;
	localparam logic [3:0] K_CLASS  = 4'd2;
	localparam logic [3:0] K_PSEUDO = 4'd3;
	localparam logic [3:0] K_PROP   = 4'd4;
	localparam logic [3:0] K_IDENT  = 4'd5;
	localparam logic [3:0] K_PUNCT  = 4'd6;
	localparam logic [3:0] K_NUMBER = 4'd7;
	localparam logic [3:0] K_OPEN   = 4'd8;
	localparam logic [3:0] K_CLOSE  = 4'd9;
	localparam logic [3:0] K_COLOR  = 4'd10;
	localparam logic [3:0] K_STOP   = 4'd11;
	localparam logic [3:0] P_HEX    = 4'd12;
	localparam logic [3:0] P_NONE   = 4'd15;

	// context modes
	localparam logic [3:0] M_TOP    = 4'd0;
	localparam logic [3:0] M_HASH   = 4'd1;
	localparam logic [3:0] M_DOT    = 4'd2;
	localparam logic [3:0] M_COLON  = 4'd3;
	localparam logic [3:0] M_NUMBER = 4'd4;
	localparam logic [3:0] M_BPROP  = 4'd5;
	localparam logic [3:0] M_APROP  = 4'd6;
	localparam logic [3:0] M_BVAL   = 4'd7;
	localparam logic [3:0] M_HEX    = 4'd8;

	// luma coefficients, unsigned 0.16
	localparam logic [15:0] LUMA_R = 16'd13933;
	localparam logic [15:0] LUMA_G = 16'd46871;
	localparam logic [15:0] LUMA_B = 16'd4732;
	localparam logic [23:0] LUMA_LIMIT = 24'd7864320; // 120 << 16

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_t;

	typedef struct packed {
		logic [3:0]           kind;
		logic [OUT_POS_W-1:0] start_pos;
		logic [OUT_POS_W-1:0] end_pos;
		logic [7:0]           bg_red;
		logic [7:0]           bg_green;
		logic [7:0]           bg_blue;
		logic                 fg_white;
		logic                 final_res;
	} tok_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic starts_name(input logic [7:0] c);
		return c == "-" || c == "_" || is_alpha(c);
	endfunction

	function automatic logic in_name(input logic [7:0] c);
		return starts_name(c) || is_digit(c);
	endfunction

	function automatic logic [3:0] nibble(input logic [7:0] c);
		logic [7:0] v;
		if (is_digit(c)) v = c - "0";
		else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
		else v = c - "a" + 8'd10;
		return v[3:0];
	endfunction

	// 1 when the colour is dark enough for white text
	function automatic logic fg_is_white(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [23:0] luma;
		luma = 24'(r * LUMA_R) + 24'(g * LUMA_G) + 24'(b * LUMA_B);
		return !(luma > LUMA_LIMIT);
	endfunction

endpackage

/* rtl/css_tc_step.sv */
// Next-state and result logic for one character of the CSS token classifier.
module css_tc_step import css_tc_pkg::*; #(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic [7:0]                ch,
	input  logic                      last,
	input  logic [3:0]                mode,
	input  logic [3:0]                pend,
	input  logic [POSITION_WIDTH-1:0] tstart,
	input  logic [POSITION_WIDTH-1:0] pos,
	input  logic [3:0]                hex [HEX_DEPTH],
	input  logic [3:0]                hcnt,
	input  logic [3:0]                fla,
	input  logic                      stopped,
	output logic [3:0]                mode_n,
	output logic [3:0]                pend_n,
	output logic [POSITION_WIDTH-1:0] tstart_n,
	output logic [POSITION_WIDTH-1:0] pos_n,
	output logic [3:0]                hex_n [HEX_DEPTH],
	output logic [3:0]                hcnt_n,
	output logic [3:0]                fla_n,
	output logic                      stopped_n,
	output tok_t                      res [MAX_RES],
	output logic [1:0]                nres
);
	logic [POSITION_WIDTH-1:0] nxt, mid, endat;
	logic [1:0]  k;
	logic        consumed, hexend, fback, colour;
	logic [7:0]  r, g, b;

	always_comb begin
		mode_n = mode; pend_n = pend; tstart_n = tstart; hcnt_n = hcnt;
		fla_n = fla; stopped_n = stopped; hex_n = hex;
		nxt = pos + 1'b1;
		pos_n = nxt;
		k = '0; consumed = 1'b0; hexend = 1'b0; fback = 1'b0;
		colour = 1'b0; r = '0; g = '0; b = '0; mid = '0; endat = pos;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '0;
		end
		if (stopped) begin
			if (last) begin
				mode_n = M_TOP; pend_n = P_NONE; tstart_n = '0; pos_n = '0;
				hcnt_n = '0; fla_n = '0; stopped_n = 1'b0;
			end
		end else begin
			// continue or close a hex run
			if (pend == P_HEX) begin
				if (is_hex(ch)) begin
					if (!hcnt[3]) hex_n[hcnt[2:0]] = nibble(ch);
					if (fla == hcnt && is_digit(ch)) fla_n = fla + 1'b1;
					hcnt_n = hcnt + 1'b1;
					if (hcnt_n >= 4'd9) fback = 1'b1;
					consumed = 1'b1;
				end else begin
					hexend = 1'b1;
				end
			end
			if (hexend) begin
				if (hcnt_n == 4'd3 || hcnt_n == 4'd4) begin
					colour = 1'b1;
					r = {hex_n[0], hex_n[0]}; g = {hex_n[1], hex_n[1]};
					b = {hex_n[2], hex_n[2]};
				end else if (hcnt_n == 4'd6 || hcnt_n == 4'd8) begin
					colour = 1'b1;
					r = {hex_n[0], hex_n[1]}; g = {hex_n[2], hex_n[3]};
					b = {hex_n[4], hex_n[5]};
				end else begin
					fback = 1'b1;
				end
				if (colour) begin
					res[k] = '{K_COLOR, OUT_POS_W'(tstart_n), OUT_POS_W'(pos),
						r, g, b, fg_is_white(r, g, b), 1'b0};
					k = k + 1'b1;
					mode_n = M_BVAL; pend_n = P_NONE;
				end
			end
			// non-colour run: leading digits as number, rest as identifier
			if (fback) begin
				mid = tstart_n + POSITION_WIDTH'(fla_n);
				if (fla_n == '0) begin
					pend_n = K_IDENT;
				end else if (fla_n >= hcnt_n) begin
					pend_n = K_NUMBER; mode_n = M_NUMBER;
				end else begin
					res[k] = '{K_NUMBER, OUT_POS_W'(tstart_n), OUT_POS_W'(mid),
						8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
					k = k + 1'b1;
					mode_n = M_NUMBER; tstart_n = mid; pend_n = K_IDENT;
				end
			end
			if (!consumed) begin
				if (pend_n <= K_IDENT && in_name(ch)) begin
					consumed = 1'b1;
				end else if (pend_n == K_NUMBER && (is_digit(ch) || ch == ".")) begin
					consumed = 1'b1;
				end else if (pend_n != P_NONE) begin
					res[k] = '{pend_n, OUT_POS_W'(tstart_n), OUT_POS_W'(pos),
						8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
					k = k + 1'b1;
					pend_n = P_NONE;
				end
			end
			// start of a new token
			if (!consumed && !is_space(ch)) begin
				if (mode_n == M_HEX && is_hex(ch)) begin
					pend_n = P_HEX; tstart_n = pos; hex_n[0] = nibble(ch);
					hcnt_n = 4'd1; fla_n = is_digit(ch) ? 4'd1 : 4'd0;
				end else if (ch == "-" && mode_n == M_BVAL) begin
					pend_n = K_NUMBER; tstart_n = pos; mode_n = M_NUMBER;
				end else if (starts_name(ch)) begin
					tstart_n = pos;
					case (mode_n)
						M_BPROP: begin pend_n = K_PROP; mode_n = M_APROP; end
						M_TOP:   pend_n = K_ELEM;
						M_HASH:  begin pend_n = K_ID; mode_n = M_TOP; end
						M_DOT:   begin pend_n = K_CLASS; mode_n = M_TOP; end
						M_COLON: begin pend_n = K_PSEUDO; mode_n = M_TOP; end
						default: pend_n = K_IDENT;
					endcase
				end else if (ch == ":" || ch == "," || ch == "#" || ch == ";"
						|| (ch == "." && mode_n == M_TOP)) begin
					if (ch == ":") begin
						if (mode_n == M_APROP) mode_n = M_BVAL;
						else if (mode_n == M_TOP) mode_n = M_COLON;
					end else if (ch == "#") begin
						mode_n = (mode_n == M_BVAL) ? M_HEX : M_HASH;
					end else if (ch == ".") begin
						mode_n = M_DOT;
					end else if (ch == ";") begin
						mode_n = M_BPROP;
					end
					res[k] = '{K_PUNCT, OUT_POS_W'(pos), OUT_POS_W'(nxt),
						8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
					k = k + 1'b1;
				end else if (is_digit(ch) || ch == ".") begin
					pend_n = K_NUMBER; tstart_n = pos; mode_n = M_NUMBER;
				end else if (ch == "(" || ch == "{" || ch == "[") begin
					if (ch == "{") mode_n = M_BPROP;
					res[k] = '{K_OPEN, OUT_POS_W'(pos), OUT_POS_W'(nxt),
						8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
					k = k + 1'b1;
				end else if (ch == ")" || ch == "}" || ch == "]") begin
					if (ch == "}") mode_n = M_TOP;
					res[k] = '{K_CLOSE, OUT_POS_W'(pos), OUT_POS_W'(nxt),
						8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
					k = k + 1'b1;
				end else begin
					stopped_n = 1'b1;
					res[k] = '{K_STOP, OUT_POS_W'(pos), OUT_POS_W'(nxt),
						8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
					k = k + 1'b1;
				end
			end
			// end of buffer: flush, then back to reset state
			if (last) begin
				if (!stopped_n) begin
					if (pend_n == P_HEX) begin
						colour = 1'b0;
						if (hcnt_n == 4'd3 || hcnt_n == 4'd4) begin
							colour = 1'b1;
							r = {hex_n[0], hex_n[0]}; g = {hex_n[1], hex_n[1]};
							b = {hex_n[2], hex_n[2]};
						end else if (hcnt_n == 4'd6 || hcnt_n == 4'd8) begin
							colour = 1'b1;
							r = {hex_n[0], hex_n[1]}; g = {hex_n[2], hex_n[3]};
							b = {hex_n[4], hex_n[5]};
						end
						if (colour) begin
							res[k] = '{K_COLOR, OUT_POS_W'(tstart_n), OUT_POS_W'(nxt),
								r, g, b, fg_is_white(r, g, b), 1'b0};
							k = k + 1'b1;
							pend_n = P_NONE;
						end else begin
							endat = tstart_n + POSITION_WIDTH'(fla_n);
							if (fla_n == '0) begin
								pend_n = K_IDENT;
							end else if (fla_n >= hcnt_n) begin
								pend_n = K_NUMBER;
							end else begin
								res[k] = '{K_NUMBER, OUT_POS_W'(tstart_n),
									OUT_POS_W'(endat), 8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
								k = k + 1'b1;
								tstart_n = endat; pend_n = K_IDENT;
							end
						end
					end
					if (pend_n != P_NONE) begin
						res[k] = '{pend_n, OUT_POS_W'(tstart_n), OUT_POS_W'(nxt),
							8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
						k = k + 1'b1;
					end
				end
				mode_n = M_TOP; pend_n = P_NONE; tstart_n = '0; pos_n = '0;
				hcnt_n = '0; fla_n = '0; stopped_n = 1'b0;
			end
		end
		if (k != '0) res[k - 1'b1].final_res = 1'b1;
		nres = k;
	end

endmodule

/* rtl/css_token_classifier.sv */
// Top level of the CSS token classifier: context state and result buffer.
//
// Takes CSS text one byte per transfer on the char channel and returns
// tokens (kind, start/end position, decoded colour and text contrast) on the
// tok channel. Each byte is classified in the cycle it is accepted; its 0 to
// 3 tokens land together in a three-entry result buffer and leave one per
// cycle while tok_ready is high, the last carrying final_res. A byte is
// taken whenever the buffer is empty or its last token is leaving in the
// same cycle; with tok_ready high, text making at most one token per byte
// streams at one byte per cycle; extra tokens hold the input as they drain.
// Positions count bytes modulo 2^POSITION_WIDTH and are shown in 32 bits.
// An unknown byte gives a stop token; later bytes are swallowed silently
// until one with last set, which only resets the context. Last on any other
// byte flushes a pending token and also resets. Hex digits of a colour run
// hold no value until written and are not cleared by reset.
module css_token_classifier import css_tc_pkg::*; #(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  char_valid,
	output logic  char_ready,
	input  char_t char_data,
	output logic  tok_valid,
	input  logic  tok_ready,
	output tok_t  tok_data
);
	// context state
	logic [3:0]                mode_q, pend_q, hcnt_q, fla_q;
	logic [POSITION_WIDTH-1:0] tstart_q, pos_q;
	logic [3:0]                hex_q [HEX_DEPTH];
	logic                      stopped_q;

	logic [3:0]                mode_n, pend_n, hcnt_n, fla_n;
	logic [POSITION_WIDTH-1:0] tstart_n, pos_n;
	logic [3:0]                hex_n [HEX_DEPTH];
	logic                      stopped_n;
	tok_t                      res [MAX_RES];
	logic [1:0]                nres;

	// result buffer
	tok_t       buf_q [MAX_RES];
	logic [1:0] cnt_q, rd_q;

	logic char_xfer, tok_xfer;

	assign tok_valid  = cnt_q != '0;
	assign tok_data   = buf_q[rd_q];
	assign tok_xfer   = tok_valid && tok_ready;
	assign char_ready = cnt_q == '0 || (cnt_q == 2'd1 && tok_ready);
	assign char_xfer  = char_valid && char_ready;

	css_tc_step #(.POSITION_WIDTH(POSITION_WIDTH)) u_step (
		.ch(char_data.ch), .last(char_data.last),
		.mode(mode_q), .pend(pend_q), .tstart(tstart_q), .pos(pos_q),
		.hex(hex_q), .hcnt(hcnt_q), .fla(fla_q), .stopped(stopped_q),
		.mode_n(mode_n), .pend_n(pend_n), .tstart_n(tstart_n), .pos_n(pos_n),
		.hex_n(hex_n), .hcnt_n(hcnt_n), .fla_n(fla_n), .stopped_n(stopped_n),
		.res(res), .nres(nres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TOP;
			pend_q <= P_NONE;
			tstart_q <= '0;
			pos_q <= '0;
			hcnt_q <= '0;
			fla_q <= '0;
			stopped_q <= 1'b0;
			cnt_q <= '0;
			rd_q <= '0;
		end else begin
			if (char_xfer) begin
				mode_q <= mode_n;
				pend_q <= pend_n;
				tstart_q <= tstart_n;
				pos_q <= pos_n;
				hcnt_q <= hcnt_n;
				fla_q <= fla_n;
				stopped_q <= stopped_n;
				cnt_q <= nres;
				rd_q <= '0;
			end else if (tok_xfer) begin
				cnt_q <= cnt_q - 1'b1;
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (char_xfer) begin
			hex_q <= hex_n;
			buf_q <= res;
		end
	end

endmodule

/* rtl/css_tc_checker.sv */
// Port-level checks for the CSS token classifier, bound to the top level.
module css_tc_checker import css_tc_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  char_valid,
	input logic  char_ready,
	input char_t char_data,
	input logic  tok_valid,
	input logic  tok_ready,
	input tok_t  tok_data
);
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid)
		else $error("token dropped while stalled");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_valid |-> char_ready)
		else $error("input blocked with empty result buffer");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> tok_data.kind <= K_STOP)
		else $error("token kind out of range");

	a_colour_only: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_data.kind != K_COLOR |-> tok_data.bg_red == 8'd0
		&& tok_data.bg_green == 8'd0 && tok_data.bg_blue == 8'd0 && !tok_data.fg_white)
		else $error("colour fields set on non-colour token");

endmodule

bind css_token_classifier css_tc_checker u_chk (.*);
